// ----- design/bulist_pkg.sv -----
// package for the bounded unique ordered list
// holds opcodes, status codes, cell commands and the beat payload structs
// no dependencies
package bulist_pkg;

    localparam int DEPTH_DEFAULT       = 8;
    localparam int VALUE_WIDTH_DEFAULT = 32;
    localparam logic [3:0] LIMIT_RESET = 4'd4;

    typedef enum logic [1:0] {
        OP_APPEND       = 2'd0,
        OP_POP          = 2'd1,
        OP_INSERT       = 2'd2,
        OP_REMOVE_AFTER = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_FULL   = 3'd1,
        ST_DUP    = 3'd2,
        ST_EMPTY  = 3'd3,
        ST_NOKEY  = 3'd4,
        ST_NOSUCC = 3'd5
    } status_t;

    // command broadcast to every cell of the row
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_APPEND,
        CELL_INSERT,
        CELL_REMOVE_AFTER,
        CELL_POP
    } cell_op_t;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [31:0] key_value;
        logic signed [31:0] new_value;
    } in_item_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [3:0]         entry_count;
        logic signed [31:0] removed_value;
        logic               removed_valid;
    } out_item_t;

endpackage

// ----- design/bounded_unique_ordered_list.sv -----
// bounded unique ordered list: row of compare-and-shift cells
// result: beat registered in the cycle after the command beat is taken
// throughput: one command per cycle if not stalled; row compares and shifts at once
// reset: occupancy 0, capacity limit 4, output empty; slot contents undefined
// depends on bulist_pkg and bulist_cell
module bounded_unique_ordered_list #(
    parameter int DEPTH       = bulist_pkg::DEPTH_DEFAULT,
    parameter int VALUE_WIDTH = bulist_pkg::VALUE_WIDTH_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  bulist_pkg::in_item_t in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output bulist_pkg::out_item_t out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [3:0]           cfg_data
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int LIM_W = (CNT_W > 4) ? CNT_W : 4;

    // state
    logic [CNT_W-1:0]        occ_reg;
    logic [CNT_W-1:0]        occ_next;
    logic [3:0]              limit_reg;
    logic                    out_valid_reg;
    bulist_pkg::out_item_t   out_data_reg;
    bulist_pkg::out_item_t   out_data_next;

    // row wiring
    logic [VALUE_WIDTH-1:0]  cell_value [DEPTH];
    logic [DEPTH-1:0]        key_match;
    logic [DEPTH-1:0]        val_match;
    logic [DEPTH-1:0]        succ_hit;
    logic [DEPTH:0]          seen;

    logic                    accept;
    bulist_pkg::cell_op_t    cell_op;
    logic [VALUE_WIDTH-1:0]  key_st;
    logic [VALUE_WIDTH-1:0]  val_st;
    logic signed [63:0]      key_wide;
    logic signed [63:0]      val_wide;
    logic [LIM_W-1:0]        limit_eff;
    logic                    full;
    logic                    empty;
    logic                    key_hit;
    logic                    val_hit;
    logic                    has_succ;
    logic [VALUE_WIDTH-1:0]  succ_value;
    logic [VALUE_WIDTH-1:0]  removed_st;
    logic signed [VALUE_WIDTH-1:0] removed_signed;
    logic signed [63:0]      removed_wide;
    bulist_pkg::status_t     status;
    logic                    removed_valid;

    // handshakes: output register parts the two sides, config always taken
    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // values sign-extended from 32 bits, kept in the low VALUE_WIDTH bits
    assign key_wide = 64'(in_data.key_value);
    assign val_wide = 64'(in_data.new_value);
    assign key_st   = key_wide[VALUE_WIDTH-1:0];
    assign val_st   = val_wide[VALUE_WIDTH-1:0];

    // effective limit: zero acts as one, anything above the depth as the depth
    always_comb
    begin
        priority if (limit_reg == 4'd0)
        begin
            limit_eff = LIM_W'(1);
        end
        else if (LIM_W'(limit_reg) > LIM_W'(DEPTH))
        begin
            limit_eff = LIM_W'(DEPTH);
        end
        else
        begin
            limit_eff = LIM_W'(limit_reg);
        end
    end

    assign full  = LIM_W'(occ_reg) >= limit_eff;
    assign empty = occ_reg == '0;

    // the cell row; seen carries "key found further left" along the chain
    assign seen[0] = 1'b0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [VALUE_WIDTH-1:0] left_v;
        logic [VALUE_WIDTH-1:0] right_v;
        logic                   left_m;

        if (i == 0)
        begin : g_head
            assign left_v = val_st;
            assign left_m = 1'b0;
        end
        else
        begin : g_body
            assign left_v = cell_value[i-1];
            assign left_m = key_match[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_v = cell_value[i];
        end
        else
        begin : g_mid
            assign right_v = cell_value[i+1];
        end

        bulist_cell #(
            .VALUE_WIDTH (VALUE_WIDTH),
            .CNT_W       (CNT_W),
            .IDX         (i)
        ) u_cell (
            .clk         (clk),
            .op          (cell_op),
            .occupancy   (occ_reg),
            .new_value   (val_st),
            .key         (key_st),
            .left_value  (left_v),
            .right_value (right_v),
            .seen_in     (seen[i]),
            .left_match  (left_m),
            .value       (cell_value[i]),
            .key_match   (key_match[i]),
            .val_match   (val_match[i]),
            .seen_out    (seen[i+1]),
            .succ_hit    (succ_hit[i])
        );
    end

    // values are unique, so at most one key hit and one successor slot
    assign key_hit  = |key_match;
    assign val_hit  = |val_match;
    assign has_succ = |succ_hit;

    always_comb
    begin
        succ_value = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            succ_value = succ_value | (succ_hit[i] ? cell_value[i] : '0);
        end
    end

    // command decode: status, cell command, new occupancy
    always_comb
    begin
        status        = bulist_pkg::ST_OK;
        cell_op       = bulist_pkg::CELL_HOLD;
        occ_next      = occ_reg;
        removed_valid = 1'b0;
        removed_st    = '0;
        unique case (bulist_pkg::op_t'(in_data.opcode))
            bulist_pkg::OP_APPEND:
            begin
                priority if (full)
                begin
                    status = bulist_pkg::ST_FULL;
                end
                else if (val_hit)
                begin
                    status = bulist_pkg::ST_DUP;
                end
                else
                begin
                    cell_op  = bulist_pkg::CELL_APPEND;
                    occ_next = occ_reg + CNT_W'(1);
                end
            end
            bulist_pkg::OP_POP:
            begin
                if (empty)
                begin
                    status = bulist_pkg::ST_EMPTY;
                end
                else
                begin
                    cell_op       = bulist_pkg::CELL_POP;
                    occ_next      = occ_reg - CNT_W'(1);
                    removed_valid = 1'b1;
                    removed_st    = cell_value[0];
                end
            end
            bulist_pkg::OP_INSERT:
            begin
                priority if (empty)
                begin
                    status = bulist_pkg::ST_EMPTY;
                end
                else if (full)
                begin
                    status = bulist_pkg::ST_FULL;
                end
                else if (val_hit)
                begin
                    status = bulist_pkg::ST_DUP;
                end
                else if (!key_hit)
                begin
                    status = bulist_pkg::ST_NOKEY;
                end
                else
                begin
                    cell_op  = bulist_pkg::CELL_INSERT;
                    occ_next = occ_reg + CNT_W'(1);
                end
            end
            bulist_pkg::OP_REMOVE_AFTER:
            begin
                priority if (!key_hit)
                begin
                    status = bulist_pkg::ST_NOKEY;
                end
                else if (!has_succ)
                begin
                    status = bulist_pkg::ST_NOSUCC;
                end
                else
                begin
                    cell_op       = bulist_pkg::CELL_REMOVE_AFTER;
                    occ_next      = occ_reg - CNT_W'(1);
                    removed_valid = 1'b1;
                    removed_st    = succ_value;
                end
            end
            default:
            begin
                status = bulist_pkg::ST_OK;
            end
        endcase
        // row only moves on an accepted beat
        if (!accept)
        begin
            cell_op  = bulist_pkg::CELL_HOLD;
            occ_next = occ_reg;
        end
    end

    // removed value reported sign-extended from the stored width
    assign removed_signed = removed_st;
    assign removed_wide   = 64'(removed_signed);

    always_comb
    begin
        out_data_next.status        = status;
        out_data_next.entry_count   = 4'(occ_next);
        out_data_next.removed_value = removed_wide[31:0];
        out_data_next.removed_valid = removed_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg       <= '0;
            limit_reg     <= bulist_pkg::LIMIT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= cfg_data;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

// ----- design/bulist_cell.sv -----
// one slot of the list row: holds a value, compares it, shifts with neighbors
// depends on bulist_pkg
module bulist_cell #(
    parameter int VALUE_WIDTH = bulist_pkg::VALUE_WIDTH_DEFAULT,
    parameter int CNT_W       = 4,
    parameter int IDX         = 0
) (
    input  logic                   clk,
    input  bulist_pkg::cell_op_t   op,
    input  logic [CNT_W-1:0]       occupancy,
    input  logic [VALUE_WIDTH-1:0] new_value,
    input  logic [VALUE_WIDTH-1:0] key,
    input  logic [VALUE_WIDTH-1:0] left_value,
    input  logic [VALUE_WIDTH-1:0] right_value,
    input  logic                   seen_in,
    input  logic                   left_match,
    output logic [VALUE_WIDTH-1:0] value,
    output logic                   key_match,
    output logic                   val_match,
    output logic                   seen_out,
    output logic                   succ_hit
);

    logic [VALUE_WIDTH-1:0] value_reg;
    logic [VALUE_WIDTH-1:0] value_next;
    logic                   occupied;
    logic                   at_tail;

    assign occupied  = CNT_W'(IDX) < occupancy;
    assign at_tail   = CNT_W'(IDX) == occupancy;
    assign key_match = occupied && (value_reg == key);
    assign val_match = occupied && (value_reg == new_value);
    // key seen at or before this slot
    assign seen_out  = seen_in | key_match;
    // this slot directly follows the key slot
    assign succ_hit  = occupied && left_match;
    assign value     = value_reg;

    always_comb
    begin
        value_next = value_reg;
        unique case (op)
            bulist_pkg::CELL_HOLD:
            begin
                value_next = value_reg;
            end
            bulist_pkg::CELL_APPEND:
            begin
                if (at_tail)
                begin
                    value_next = new_value;
                end
            end
            bulist_pkg::CELL_INSERT:
            begin
                if (seen_in)
                begin
                    value_next = left_value;
                end
                else if (key_match)
                begin
                    value_next = new_value;
                end
            end
            bulist_pkg::CELL_REMOVE_AFTER:
            begin
                if (seen_in)
                begin
                    value_next = right_value;
                end
            end
            bulist_pkg::CELL_POP:
            begin
                value_next = right_value;
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

// ----- design/bulist_checker.sv -----
// port-level checks for the bounded unique ordered list, bound to the top level
// depends on bulist_pkg and bounded_unique_ordered_list
module bulist_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input bulist_pkg::in_item_t  in_data,
    input logic                  out_valid,
    input logic                  out_ready,
    input bulist_pkg::out_item_t out_data,
    input logic                  cfg_valid,
    input logic                  cfg_ready,
    input logic [3:0]            cfg_data
);

    // a taken command beat shows its result in the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("no result beat after an accepted command");

    // a stalled result beat stays
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result beat changed or dropped");

    // a removal only comes with ok status
    a_removed_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.removed_valid |->
            out_data.status == bulist_pkg::ST_OK)
        else $error("removed value flagged on a refused command");

    // refused commands report no removed value
    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != bulist_pkg::ST_OK |->
            !out_data.removed_valid && out_data.removed_value == 32'sd0)
        else $error("refused command reports a removed value");

endmodule

bind bounded_unique_ordered_list bulist_checker u_bulist_checker (.*);

// ----- test/tb_bounded_unique_ordered_list.sv -----
// testbench for bounded_unique_ordered_list: random and directed list commands with a
// shadow list that predicts every status beat, checked field by field
// depends on bulist_pkg and the bounded_unique_ordered_list rtl
module tb_bounded_unique_ordered_list;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          LIST_DEPTH   = bulist_pkg::DEPTH_DEFAULT;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          HOLD_CYCLES  = 40;
    localparam int          PHASE_ITEMS  = 75;
    localparam logic [31:0] VAL_MIN      = 32'h8000_0000;
    localparam logic [31:0] VAL_MAX      = 32'h7FFF_FFFF;
    localparam logic [31:0] VAL_ALL_ONES = 32'hFFFF_FFFF;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    bulist_pkg::in_item_t  in_data = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    bulist_pkg::out_item_t out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [3:0]            cfg_data = '0;

    // shadow copy of the list, advanced once per accepted command beat
    logic [31:0] shadow_slots [LIST_DEPTH];
    int          shadow_count = 0;
    logic [3:0]  shadow_limit = bulist_pkg::LIMIT_RESET;

    // commands waiting for the driver, status beats waiting for the dut
    bulist_pkg::in_item_t  pending_cmds[$];
    bulist_pkg::out_item_t expected_status_beats[$];
    logic [31:0]           value_pool[$];

    // handshake flags passed from the sampling edge to the driving edge
    bit cmd_taken = 1'b0;
    bit res_taken = 1'b0;
    int src_wait = 0;
    int sink_wait = 0;
    bit src_burst = 1'b0;
    bit sink_burst = 1'b0;
    int hold_requests = 0;
    int hold_served = 0;

    int cycle_count = 0;
    int error_count = 0;
    int limit_writes = 0;
    int op_seen [4] = '{default: 0};
    int status_seen [8] = '{default: 0};

    bounded_unique_ordered_list dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // position of a value in the shadow list, or the count when absent
    function automatic int slot_of(input logic [31:0] v);
        for (int i = 0; i < shadow_count; i++)
        begin
            if (shadow_slots[i] == v)
                return i;
        end
        return shadow_count;
    endfunction

    // close the gap left by a removed entry
    function automatic void drop_slot(input int pos);
        for (int i = pos; i + 1 < shadow_count; i++)
            shadow_slots[i] = shadow_slots[i + 1];
        shadow_count--;
    endfunction

    // one list command against the shadow list, giving the status beat it must produce
    task automatic apply_list_command(input bulist_pkg::in_item_t c,
                                      output bulist_pkg::out_item_t r);
        int          limit_now;
        int          pos;
        logic [31:0] key;
        logic [31:0] val;
        bit          full;
        key = c.key_value;
        val = c.new_value;
        r = '0;
        r.status = bulist_pkg::ST_OK;
        // a zero limit acts as one, anything past the depth as the depth
        limit_now = (shadow_limit == 0) ? 1 :
                    (shadow_limit > LIST_DEPTH) ? LIST_DEPTH : int'(shadow_limit);
        // a limit lowered under the occupancy simply keeps the list full
        full = shadow_count >= limit_now;
        case (bulist_pkg::op_t'(c.opcode))
            bulist_pkg::OP_APPEND:
            begin
                if (full)
                    r.status = bulist_pkg::ST_FULL;
                else if (slot_of(val) < shadow_count)
                    r.status = bulist_pkg::ST_DUP;
                else
                begin
                    shadow_slots[shadow_count] = val;
                    shadow_count++;
                end
            end
            bulist_pkg::OP_POP:
            begin
                if (shadow_count == 0)
                    r.status = bulist_pkg::ST_EMPTY;
                else
                begin
                    r.removed_value = shadow_slots[0];
                    r.removed_valid = 1'b1;
                    drop_slot(0);
                end
            end
            bulist_pkg::OP_INSERT:
            begin
                // empty first, then full, then duplicate (key itself counts), then missing key
                if (shadow_count == 0)
                    r.status = bulist_pkg::ST_EMPTY;
                else if (full)
                    r.status = bulist_pkg::ST_FULL;
                else if (slot_of(val) < shadow_count)
                    r.status = bulist_pkg::ST_DUP;
                else
                begin
                    pos = slot_of(key);
                    if (pos >= shadow_count)
                        r.status = bulist_pkg::ST_NOKEY;
                    else
                    begin
                        for (int i = shadow_count; i > pos; i--)
                            shadow_slots[i] = shadow_slots[i - 1];
                        shadow_slots[pos] = val;
                        shadow_count++;
                    end
                end
            end
            default:
            begin
                // remove-after: an empty list also reports the key as missing
                pos = slot_of(key);
                if (pos >= shadow_count)
                    r.status = bulist_pkg::ST_NOKEY;
                else if (pos + 1 >= shadow_count)
                    r.status = bulist_pkg::ST_NOSUCC;
                else
                begin
                    r.removed_value = shadow_slots[pos + 1];
                    r.removed_valid = 1'b1;
                    drop_slot(pos + 1);
                end
            end
        endcase
        r.entry_count = 4'(shadow_count);
        op_seen[c.opcode]++;
        status_seen[r.status]++;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t mismatch on %s: expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endtask

    // sampling edge: score result beats, predict command beats, track the limit register
    always @(posedge clk)
    begin
        bulist_pkg::out_item_t want;
        if (rst_n)
        begin
            cycle_count++;
            // score first, a result beat never belongs to a command taken on the same edge
            if (out_valid && out_ready)
            begin
                if (expected_status_beats.size() == 0)
                begin
                    $display("%0t unexpected result beat: expected none, actual %0h",
                             $time, out_data);
                    error_count++;
                end
                else
                begin
                    want = expected_status_beats.pop_front();
                    check_field("status", 32'(want.status), 32'(out_data.status));
                    check_field("entry_count", 32'(want.entry_count),
                                32'(out_data.entry_count));
                    check_field("removed_value", want.removed_value, out_data.removed_value);
                    check_field("removed_valid", 32'(want.removed_valid),
                                32'(out_data.removed_valid));
                end
                res_taken = 1'b1;
            end
            if (in_valid && in_ready)
            begin
                apply_list_command(in_data, want);
                expected_status_beats.push_back(want);
                cmd_taken = 1'b1;
            end
            if (cfg_valid && cfg_ready)
                shadow_limit = cfg_data;
        end
    end

    // command driver: random gap before each beat, payload held until taken
    always @(negedge clk)
    begin
        bit waiting;
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            // a beat on offer that was not taken stays as it is
            waiting = in_valid && !cmd_taken;
            if (cmd_taken)
            begin
                cmd_taken = 1'b0;
                // occasionally switch between gappy traffic and back-to-back bursts
                if ($urandom_range(0, 31) == 0)
                    src_burst = !src_burst;
                src_wait = src_burst ? 0 : $urandom_range(0, 7);
            end
            if (waiting)
            begin
                in_valid <= 1'b1;
            end
            else if (src_wait > 0)
            begin
                src_wait--;
                in_valid <= 1'b0;
            end
            else if (pending_cmds.size() != 0)
            begin
                in_data  <= pending_cmds.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result receiver: random stall per beat plus long hold-offs on request
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (res_taken)
            begin
                res_taken = 1'b0;
                if ($urandom_range(0, 31) == 0)
                    sink_burst = !sink_burst;
                sink_wait = sink_burst ? 0 : $urandom_range(0, 7);
            end
            // long hold-off so the dut backs up and drops in_ready
            if (hold_served != hold_requests)
            begin
                hold_served = hold_requests;
                sink_wait = HOLD_CYCLES;
            end
            if (sink_wait > 0)
            begin
                sink_wait--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // watchdog
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("%0t timeout after %0d cycles", $time, cycle_count);
        $display("[bounded_unique_ordered_list] ERROR");
        $finish;
    end

    task automatic push_cmd(input bulist_pkg::op_t op, input logic [31:0] key,
                            input logic [31:0] val);
        bulist_pkg::in_item_t c;
        c.opcode    = op;
        c.key_value = key;
        c.new_value = val;
        pending_cmds.push_back(c);
    endtask

    // idle means nothing queued, nothing on offer and no status beat outstanding
    task automatic wait_quiet();
        do
            @(posedge clk);
        while (pending_cmds.size() != 0 || in_valid || expected_status_beats.size() != 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_limit(input logic [3:0] lim);
        @(negedge clk);
        cfg_data  <= lim;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        limit_writes++;
        @(posedge clk);
    endtask

    initial
    begin
        logic [3:0]      limit_plan [8];
        logic [3:0]      lim;
        int              eff;
        int              pick;
        bulist_pkg::op_t op;

        // reset held at the start, released away from the sampling edge
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part at the reset limit of four entries
        push_cmd(bulist_pkg::OP_POP, '0, '0);                    // pop on empty list
        push_cmd(bulist_pkg::OP_REMOVE_AFTER, '0, '0);           // remove-after on empty list
        push_cmd(bulist_pkg::OP_INSERT, '0, 32'd1);              // insert on empty list
        push_cmd(bulist_pkg::OP_APPEND, VAL_ALL_ONES, VAL_MIN);
        push_cmd(bulist_pkg::OP_REMOVE_AFTER, VAL_MIN, '0);      // only entry, no successor
        push_cmd(bulist_pkg::OP_APPEND, '0, VAL_MAX);
        push_cmd(bulist_pkg::OP_APPEND, '0, VAL_MIN);            // duplicate append
        push_cmd(bulist_pkg::OP_APPEND, '0, '0);
        push_cmd(bulist_pkg::OP_APPEND, '0, VAL_ALL_ONES);       // list now at its limit
        push_cmd(bulist_pkg::OP_APPEND, '0, 32'd5);              // full
        push_cmd(bulist_pkg::OP_APPEND, '0, VAL_MIN);            // full wins over duplicate
        push_cmd(bulist_pkg::OP_INSERT, '0, 32'd7);              // insert while full
        push_cmd(bulist_pkg::OP_REMOVE_AFTER, VAL_ALL_ONES, '0); // key is the tail
        push_cmd(bulist_pkg::OP_REMOVE_AFTER, 32'd12345, '0);    // key absent
        push_cmd(bulist_pkg::OP_REMOVE_AFTER, VAL_MAX, '0);      // takes out the zero entry
        push_cmd(bulist_pkg::OP_INSERT, VAL_MAX, VAL_MAX);       // new value equals the key
        push_cmd(bulist_pkg::OP_INSERT, 32'd99, VAL_ALL_ONES);   // duplicate before key check
        push_cmd(bulist_pkg::OP_INSERT, 32'd99, 32'd42);         // key absent
        push_cmd(bulist_pkg::OP_INSERT, VAL_MIN, 32'd42);        // insert at the head
        push_cmd(bulist_pkg::OP_INSERT, VAL_ALL_ONES, 32'd43);   // full again
        push_cmd(bulist_pkg::OP_POP, VAL_ALL_ONES, VAL_ALL_ONES);
        push_cmd(bulist_pkg::OP_INSERT, VAL_ALL_ONES, 32'd43);   // insert before the tail
        repeat (5) push_cmd(bulist_pkg::OP_POP, '0, '0);         // drain, last finds it empty

        // limit settings: extremes, out-of-range codes, random picks, back to reset value
        limit_plan = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd2, 4'd0, 4'd0, bulist_pkg::LIMIT_RESET};
        limit_plan[5] = 4'($urandom_range(0, 15));
        limit_plan[6] = 4'($urandom_range(0, 15));

        foreach (limit_plan[p])
        begin
            lim = limit_plan[p];
            wait_quiet();
            write_limit(lim);

            // small value pool so keys hit and duplicates show up often
            eff = (lim == 0) ? 1 : (lim > LIST_DEPTH) ? LIST_DEPTH : int'(lim);
            value_pool.delete();
            repeat (eff + 4)
            begin
                case ($urandom_range(0, 9))
                    0: value_pool.push_back(VAL_MIN);
                    1: value_pool.push_back(VAL_MAX);
                    2: value_pool.push_back('0);
                    default: value_pool.push_back($urandom);
                endcase
            end

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // mostly pool-based commands, some fully random noise
                if ($urandom_range(0, 6) == 0)
                    push_cmd(bulist_pkg::op_t'($urandom_range(0, 3)), $urandom, $urandom);
                else
                begin
                    pick = $urandom_range(0, 19);
                    op = (pick < 7) ? bulist_pkg::OP_APPEND :
                         (pick < 10) ? bulist_pkg::OP_POP :
                         (pick < 15) ? bulist_pkg::OP_INSERT : bulist_pkg::OP_REMOVE_AFTER;
                    push_cmd(op, value_pool[$urandom_range(0, value_pool.size() - 1)],
                             value_pool[$urandom_range(0, value_pool.size() - 1)]);
                end
            end

            // stall the receiver while the sender keeps offering
            if (p == 0 || p == 3)
                hold_requests++;

            // fill up before the limit drops to one, leaving the list over its new limit
            if (p == 0)
                repeat (LIST_DEPTH) push_cmd(bulist_pkg::OP_APPEND, $urandom, $urandom);
        end

        wait_quiet();

        $display("covered %0d commands (%0d append, %0d pop, %0d insert, %0d remove-after)",
                 op_seen[0] + op_seen[1] + op_seen[2] + op_seen[3],
                 op_seen[bulist_pkg::OP_APPEND], op_seen[bulist_pkg::OP_POP],
                 op_seen[bulist_pkg::OP_INSERT], op_seen[bulist_pkg::OP_REMOVE_AFTER]);
        $display("over %0d limit writes; outcomes: %0d ok, %0d full, %0d duplicate, %0d empty,",
                 limit_writes, status_seen[bulist_pkg::ST_OK], status_seen[bulist_pkg::ST_FULL],
                 status_seen[bulist_pkg::ST_DUP], status_seen[bulist_pkg::ST_EMPTY]);
        $display("%0d key missing, %0d no successor",
                 status_seen[bulist_pkg::ST_NOKEY], status_seen[bulist_pkg::ST_NOSUCC]);
        if (error_count == 0)
            $display("[bounded_unique_ordered_list] OK");
        else
            $display("[bounded_unique_ordered_list] ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
design/bulist_pkg.sv
design/bulist_cell.sv
design/bounded_unique_ordered_list.sv
design/bulist_checker.sv
test/tb_bounded_unique_ordered_list.sv
